>>> rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg: shared types and constants of the moving average clamp
// Window size, field widths, controller states and the structs that link
// the controller to the sample ring and to the divider.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int unsigned WINDOW   = 10;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 12;
  localparam int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  // Exact running sum: magnitude up to WINDOW * 2^15, plus sign.
  localparam int unsigned SUM_W    = SAMPLE_W + $clog2(WINDOW);
  // Divider works on the non-negative sum, so it drops the sign bit.
  localparam int unsigned QUO_W    = SUM_W - 1;
  localparam int unsigned STEP_W   = $clog2(QUO_W);

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [SLOT_W-1:0]   addr;
    logic [SAMPLE_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_result_t;

endpackage

>>> rtl/mavg_ring.sv
// ----------------------------------------------------------------------------
// mavg_ring: sample ring storage
// Single-port synchronous memory of WINDOW samples with registered read data.
// ----------------------------------------------------------------------------
module mavg_ring (
  input  logic                          clk_i,
  input  mavg_pkg::ring_req_t           req_i,
  output logic [mavg_pkg::SAMPLE_W-1:0] rdata_o
);
  import mavg_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [WINDOW];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mavg_pkg::QUO_W-1:0] dividend_i,
  input  logic [mavg_pkg::CNT_W-1:0] divisor_i,
  output mavg_pkg::div_result_t      result_o
);
  import mavg_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [QUO_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;

  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_shift = {rem_q, quo_q[QUO_W-1]};
  assign fits      = rem_shift >= {1'b0, div_q};
  assign rem_diff  = rem_shift - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Shift in one quotient bit per step; remainder stays below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QUO_W-2:0], fits};
      rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end
  end

  assign result_o.done     = done_q;
  assign result_o.quotient = quo_q;

endmodule

>>> rtl/moving_average_clamp_top.sv
// ----------------------------------------------------------------------------
// moving_average_clamp_top: boxcar moving average with output clamp
// Per item: the ring is read on accept, then written with the sum update,
// the divider is started, divides bit-serially and signals done, and the output loads.
// A new item is taken only after the previous result is loaded, so the bit-serial
// divider limits the item rate, and a stalled finished result holds it up further.
// Reset: ring sum, write slot and fill count clear; no clearing pass needed.
// ----------------------------------------------------------------------------
module moving_average_clamp_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mavg_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mavg_pkg::OUT_W-1:0]    out_smoothed_o
);
  import mavg_pkg::*;

  // Controller state and datapath registers.
  state_e              state_q, state_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_q;

  // Control outputs of the state machine.
  ring_req_t           ring_req;
  logic                div_start;
  logic                load_out;
  logic                accept;

  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] old_sample;
  logic                ring_full;
  div_result_t         div_res;
  logic [QUO_W-1:0]    dividend;
  logic [OUT_W-1:0]    clamped;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // Sample ring: read the slot on accept, write the new sample to it in the update cycle.
  // One item is in flight at a time, so read and write never collide.
  mavg_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  // Slots are written in order, so until the ring is full the slot about
  // to be replaced was never written; zero stands in for its old sample.
  assign ring_full  = (fill_q == CNT_W'(WINDOW));
  assign old_sample = ring_full ? ring_rdata : '0;

  // A negative sum gives a quotient at or below zero, which clamps to zero:
  // divide zero instead.
  assign dividend = sum_q[SUM_W-1] ? '0 : sum_q[QUO_W-1:0];

  mavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .result_o   (div_res)
  );

  // Clamp the quotient to the output range.
  assign clamped = (|div_res.quotient[QUO_W-1:OUT_W]) ? OUT_MAX
                                                       : div_res.quotient[OUT_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_START;
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_res.done) state_d = ST_OUTPUT;
      ST_OUTPUT: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_stall_o     = 1'b1;
    ring_req.rd_en = 1'b0;
    ring_req.wr_en = 1'b0;
    ring_req.addr  = slot_q;
    ring_req.wdata = sample_q;
    div_start      = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        ring_req.rd_en = in_valid_i;
      end
      ST_UPDATE: begin
        ring_req.wr_en = 1'b1;
      end
      ST_START: begin
        div_start = 1'b1;
      end
      ST_OUTPUT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Running sum, write slot and fill count advance in the update cycle.
  always_comb begin
    sum_d  = sum_q;
    slot_d = slot_q;
    fill_d = fill_q;
    if (state_q == ST_UPDATE) begin
      sum_d  = sum_q - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample}
                     + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
      slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
      if (!ring_full) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  // Output register: drop the item when taken, load a new one when free.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the accepted sample and the loaded result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_sample_i;
    end
    if (load_out) begin
      out_q <= clamped;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_smoothed_o = out_q;

endmodule

>>> rtl/mavg_checker.sv
// ----------------------------------------------------------------------------
// mavg_checker: port-level checks for the moving average clamp
// Watches the top-level handshakes and flags sequencing slips.
// ----------------------------------------------------------------------------
module mavg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [mavg_pkg::SAMPLE_W-1:0] in_sample_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mavg_pkg::OUT_W-1:0]    out_smoothed_o
);

  // Stalled input item holds its value.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_sample_i))
    else $error("stalled input item changed");

  // Stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_smoothed_o))
    else $error("stalled result changed");

  // One item at a time: the block stalls right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // No result appears in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // A new result is loaded only from the busy phase.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while idle");

endmodule

bind moving_average_clamp_top mavg_checker u_mavg_checker (.*);
